### rtl/rgbh_pkg.sv
// ----------------------------------------------------------------------------
// rgbh_pkg
// Shared constants and pipeline types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbh_pkg;

  localparam int CHAN_W     = 8;
  localparam int HUE_FRAC_W = 4;
  localparam int HUE_W      = 13;
  localparam int CMAX       = (2 ** CHAN_W) - 1;
  localparam int SECTOR     = 60 * (2 ** HUE_FRAC_W);
  localparam int CIRCLE     = 6 * SECTOR;
  localparam int HQ_W       = $clog2(SECTOR + 1);
  localparam int Q_W        = (HQ_W > CHAN_W) ? HQ_W : CHAN_W;
  localparam int NUM_W      = CHAN_W + Q_W;
  localparam int REM_W      = CHAN_W + 1;
  localparam int LATENCY    = Q_W + 2;

  // one long division in flight: numerator bits shift out, quotient bits in
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [REM_W-1:0]  rem;
    logic [CHAN_W-1:0] div;
  } lane_t;

  typedef struct packed {
    logic              valid;
    lane_t             sat;
    lane_t             hue;
    logic              neg;
    logic [HUE_W-1:0]  base;
    logic [CHAN_W-1:0] value;
    logic              undef;
  } stage_t;

endpackage

### rtl/rgbh_front.sv
// ----------------------------------------------------------------------------
// rgbh_front
// Picks the largest channel, forms delta and the two division numerators.
// ----------------------------------------------------------------------------
module rgbh_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [rgbh_pkg::CHAN_W-1:0]  red_in,
  input  logic [rgbh_pkg::CHAN_W-1:0]  green_in,
  input  logic [rgbh_pkg::CHAN_W-1:0]  blue_in,
  output rgbh_pkg::stage_t             stage
);
  import rgbh_pkg::*;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  logic [1:0]        sel;
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] delta;
  logic [CHAN_W-1:0] opa;
  logic [CHAN_W-1:0] opb;
  logic [CHAN_W-1:0] mag;
  logic              neg;
  logic [HUE_W-1:0]  base;
  logic [NUM_W-1:0]  sat_num;
  logic [NUM_W-1:0]  hue_num;
  stage_t            stage_next;

  always_comb begin
    if (red_in > green_in && red_in > blue_in) begin
      sel = SEL_RED;
      mx  = red_in;
    end else if (green_in > blue_in) begin
      sel = SEL_GREEN;
      mx  = green_in;
    end else begin
      sel = SEL_BLUE;
      mx  = blue_in;
    end
    mn = red_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    delta = mx - mn;

    unique case (sel)
      SEL_RED: begin
        opa  = green_in;
        opb  = blue_in;
        base = '0;
      end
      SEL_GREEN: begin
        opa  = blue_in;
        opb  = red_in;
        base = HUE_W'(2 * SECTOR);
      end
      default: begin
        opa  = red_in;
        opb  = green_in;
        base = HUE_W'(4 * SECTOR);
      end
    endcase
    neg = opa < opb;
    mag = neg ? (opb - opa) : (opa - opb);

    sat_num = NUM_W'(CMAX) * NUM_W'(delta);
    hue_num = NUM_W'(SECTOR) * NUM_W'(mag);

    stage_next.valid     = accept;
    stage_next.sat.rem   = {1'b0, sat_num[NUM_W-1:Q_W]};
    stage_next.sat.num   = {sat_num[Q_W-1:0], {CHAN_W{1'b0}}};
    stage_next.sat.div   = mx;
    stage_next.hue.rem   = {1'b0, hue_num[NUM_W-1:Q_W]};
    stage_next.hue.num   = {hue_num[Q_W-1:0], {CHAN_W{1'b0}}};
    stage_next.hue.div   = delta;
    stage_next.neg       = neg;
    stage_next.base      = base;
    stage_next.value     = mx;
    // black pixels have delta zero as well
    stage_next.undef     = (delta == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= stage_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage.sat   <= stage_next.sat;
    stage.hue   <= stage_next.hue;
    stage.neg   <= stage_next.neg;
    stage.base  <= stage_next.base;
    stage.value <= stage_next.value;
    stage.undef <= stage_next.undef;
  end

endmodule

### rtl/rgbh_cell.sv
// ----------------------------------------------------------------------------
// rgbh_cell
// One restoring division step for both the saturation and hue quotients.
// ----------------------------------------------------------------------------
module rgbh_cell (
  input  logic             clk,
  input  logic             rst,
  input  rgbh_pkg::stage_t stage_in,
  output rgbh_pkg::stage_t stage_out
);
  import rgbh_pkg::*;

  lane_t  sat_next;
  lane_t  hue_next;
  logic [REM_W-1:0] sat_trial;
  logic [REM_W-1:0] hue_trial;
  logic             sat_ge;
  logic             hue_ge;

  always_comb begin
    sat_trial = {stage_in.sat.rem[REM_W-2:0], stage_in.sat.num[NUM_W-1]};
    sat_ge    = sat_trial >= {1'b0, stage_in.sat.div};
    sat_next.rem = sat_ge ? (sat_trial - {1'b0, stage_in.sat.div}) : sat_trial;
    sat_next.num = {stage_in.sat.num[NUM_W-2:0], sat_ge};
    sat_next.div = stage_in.sat.div;

    hue_trial = {stage_in.hue.rem[REM_W-2:0], stage_in.hue.num[NUM_W-1]};
    hue_ge    = hue_trial >= {1'b0, stage_in.hue.div};
    hue_next.rem = hue_ge ? (hue_trial - {1'b0, stage_in.hue.div}) : hue_trial;
    hue_next.num = {stage_in.hue.num[NUM_W-2:0], hue_ge};
    hue_next.div = stage_in.hue.div;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_out.sat   <= sat_next;
    stage_out.hue   <= hue_next;
    stage_out.neg   <= stage_in.neg;
    stage_out.base  <= stage_in.base;
    stage_out.value <= stage_in.value;
    stage_out.undef <= stage_in.undef;
  end

endmodule

### rtl/rgbh_back.sv
// ----------------------------------------------------------------------------
// rgbh_back
// Applies sector base, floor rounding and wrap, and registers the result.
// ----------------------------------------------------------------------------
module rgbh_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rgbh_pkg::stage_t             stage,
  output logic                         done,
  output logic [rgbh_pkg::HUE_W-1:0]   hue_out,
  output logic                         hue_undefined,
  output logic [rgbh_pkg::CHAN_W-1:0]  saturation_out,
  output logic [rgbh_pkg::CHAN_W-1:0]  value_out
);
  import rgbh_pkg::*;

  logic [HUE_W:0]    mag;
  logic [HUE_W:0]    sum;
  logic [HUE_W:0]    wrapped;
  logic [HUE_W-1:0]  hue_next;
  logic [CHAN_W-1:0] sat_next;

  always_comb begin
    // negative differences round down, so a non-zero remainder adds one
    mag = (HUE_W + 1)'(stage.hue.num[Q_W-1:0])
        + (HUE_W + 1)'(stage.neg && (stage.hue.rem != '0));
    sum = stage.neg ? ({1'b0, stage.base} - mag) : ({1'b0, stage.base} + mag);
    wrapped  = sum[HUE_W] ? (sum + (HUE_W + 1)'(CIRCLE)) : sum;
    hue_next = stage.undef ? '0 : wrapped[HUE_W-1:0];
    sat_next = stage.undef ? '0 : stage.sat.num[CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_out        <= hue_next;
    hue_undefined  <= stage.undef;
    saturation_out <= sat_next;
    value_out      <= stage.value;
  end

endmodule

### rtl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv
// RGB to HSV pixel converter built as a pipelined chain of division cells.
// ----------------------------------------------------------------------------
// One pixel may be requested on every clock: busy is never raised, since the
// receiver cannot stall and nothing inside waits. Each request comes out with
// done high for one cycle; between request and result lie one input stage,
// one stage per quotient bit of the ten-cell division chain and one output
// register. Hue is in sixteenths of a degree (0..5759); grey and black
// pixels give hue_undefined with hue and saturation zero.
module rgb_to_hsv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rgbh_pkg::CHAN_W-1:0]  red_in,
  input  logic [rgbh_pkg::CHAN_W-1:0]  green_in,
  input  logic [rgbh_pkg::CHAN_W-1:0]  blue_in,
  output logic                         done,
  output logic [rgbh_pkg::HUE_W-1:0]   hue_out,
  output logic                         hue_undefined,
  output logic [rgbh_pkg::CHAN_W-1:0]  saturation_out,
  output logic [rgbh_pkg::CHAN_W-1:0]  value_out
);
  import rgbh_pkg::*;

  stage_t chain [Q_W+1];
  logic   accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rgbh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .stage    (chain[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    rgbh_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  rgbh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .stage          (chain[Q_W]),
    .done           (done),
    .hue_out        (hue_out),
    .hue_undefined  (hue_undefined),
    .saturation_out (saturation_out),
    .value_out      (value_out)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("request did not complete after pipeline latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching request");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    done && hue_undefined |-> hue_out == '0 && saturation_out == '0)
    else $error("undefined hue with non-zero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hue_out < HUE_W'(CIRCLE))
    else $error("hue beyond full circle");

  a_colour_sat: assert property (@(posedge clk) disable iff (rst)
    done && !hue_undefined |-> saturation_out != '0 && value_out != '0)
    else $error("coloured pixel with zero saturation or value");
`endif

endmodule

### test/tb_rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv
// Self-checking bench for the RGB to HSV converter: directed corner pixels
// then random pixels under three idling mixes, each request's hue, undefined
// flag, saturation and value predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv;

  import rgbh_pkg::*;

  typedef enum int {SECT_RED, SECT_GREEN, SECT_BLUE} hue_sector_t;

  typedef struct {
    logic [HUE_W-1:0]  hue;
    logic              undef;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
  } hsv_t;

  class hsv_tracker_t;
    hsv_t awaited_hsv[$];
    int   failures = 0;

    function int floor_quot(int num, int den);
      if (num >= 0) begin
        return num / den;
      end
      return -((-num + den - 1) / den);
    endfunction

    function hsv_t convert_pixel(int r, int g, int b);
      int          mx;
      int          mn;
      int          delta;
      int          hue;
      hue_sector_t sector;
      hsv_t        h;
      if (r > g && r > b) begin
        sector = SECT_RED;
        mx = r;
      end else if (g > b) begin
        sector = SECT_GREEN;
        mx = g;
      end else begin
        sector = SECT_BLUE;
        mx = b;
      end
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      h.val = mx[CHAN_W-1:0];
      if (mx == 0 || delta == 0) begin
        h.hue = '0;
        h.undef = 1'b1;
        h.sat = '0;
        return h;
      end
      h.undef = 1'b0;
      h.sat = CHAN_W'(CMAX * delta / mx);
      case (sector)
        SECT_RED:   hue = floor_quot(SECTOR * (g - b), delta);
        SECT_GREEN: hue = 2 * SECTOR + floor_quot(SECTOR * (b - r), delta);
        default:    hue = 4 * SECTOR + floor_quot(SECTOR * (r - g), delta);
      endcase
      if (hue < 0) hue += CIRCLE;
      h.hue = hue[HUE_W-1:0];
      return h;
    endfunction

    function void note_pixel(int r, int g, int b);
      awaited_hsv.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_result(hsv_t got);
      hsv_t want;
      if (awaited_hsv.size() == 0) begin
        failures++;
        $display("%0t: unexpected result hue %0d undef %0b sat %0d val %0d",
                 $time, got.hue, got.undef, got.sat, got.val);
        return;
      end
      want = awaited_hsv.pop_front();
      if (got.hue !== want.hue) begin
        failures++;
        $display("%0t: hue_out expected %0d actual %0d", $time, want.hue, got.hue);
      end
      if (got.undef !== want.undef) begin
        failures++;
        $display("%0t: hue_undefined expected %0b actual %0b", $time, want.undef,
                 got.undef);
      end
      if (got.sat !== want.sat) begin
        failures++;
        $display("%0t: saturation_out expected %0d actual %0d", $time, want.sat,
                 got.sat);
      end
      if (got.val !== want.val) begin
        failures++;
        $display("%0t: value_out expected %0d actual %0d", $time, want.val, got.val);
      end
    endfunction

    function int outstanding();
      return awaited_hsv.size();
    endfunction

    function void close_out();
      if (awaited_hsv.size() != 0) begin
        failures++;
        $display("%0t: %0d results never arrived", $time, awaited_hsv.size());
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAN_W-1:0] red_in = '0;
  logic [CHAN_W-1:0] green_in = '0;
  logic [CHAN_W-1:0] blue_in = '0;
  logic              done;
  logic [HUE_W-1:0]  hue_out;
  logic              hue_undefined;
  logic [CHAN_W-1:0] saturation_out;
  logic [CHAN_W-1:0] value_out;

  hsv_tracker_t tracker = new();

  rgb_to_hsv i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .red_in         (red_in),
    .green_in       (green_in),
    .blue_in        (blue_in),
    .done           (done),
    .hue_out        (hue_out),
    .hue_undefined  (hue_undefined),
    .saturation_out (saturation_out),
    .value_out      (value_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // requests and results seen at the rising edge
  always @(posedge clk) begin
    hsv_t got;
    if (!rst) begin
      if (start && !busy) begin
        tracker.note_pixel(int'(red_in), int'(green_in), int'(blue_in));
      end
      if (done) begin
        got.hue = hue_out;
        got.undef = hue_undefined;
        got.sat = saturation_out;
        got.val = value_out;
        tracker.check_result(got);
      end
    end
  end

  task automatic send_pixel(int r, int g, int b);
    @(negedge clk);
    start <= 1'b1;
    red_in <= CHAN_W'(r);
    green_in <= CHAN_W'(g);
    blue_in <= CHAN_W'(b);
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    idle_cycles(1);
    while (tracker.outstanding() != 0 && guard < 20 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic random_pixel(output int r, output int g, output int b);
    int shape;
    shape = $urandom_range(0, 99);
    r = $urandom_range(0, CMAX);
    g = $urandom_range(0, CMAX);
    b = $urandom_range(0, CMAX);
    if (shape < 10) begin
      // grey
      g = r;
      b = r;
    end else if (shape < 22) begin
      // two channels tied
      case ($urandom_range(0, 2))
        0: g = r;
        1: b = r;
        default: b = g;
      endcase
    end else if (shape < 30) begin
      r = $urandom_range(0, 3);
      g = $urandom_range(0, 3);
      b = $urandom_range(0, 3);
    end
  endtask

  task automatic random_phase(int count, int idle_pct);
    int r;
    int g;
    int b;
    repeat (count) begin
      while ($urandom_range(0, 99) < idle_pct) idle_cycles(1);
      random_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // black, white, grey
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(1, 1, 1);
    // primaries and secondaries
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    // ties for the largest channel
    send_pixel(200, 200, 10);
    send_pixel(200, 10, 200);
    send_pixel(10, 200, 200);
    // negative hue wraps, with floor on a negative difference
    send_pixel(255, 0, 1);
    send_pixel(200, 10, 13);
    send_pixel(255, 254, 255);
    // small and near-extreme values
    send_pixel(1, 0, 0);
    send_pixel(0, 1, 1);
    send_pixel(1, 2, 3);
    send_pixel(255, 254, 0);
    send_pixel(254, 255, 255);
    send_pixel(170, 85, 0);
    send_pixel(3, 0, 2);
    drain_results();

    random_phase(600, 19);
    drain_results();
    random_phase(600, 71);
    drain_results();
    random_phase(600, 0);

    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    tracker.close_out();
    if (tracker.failures == 0) begin
      $display("tb_rgb_to_hsv: PASS");
    end else begin
      $display("tb_rgb_to_hsv: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_rgb_to_hsv: FAIL");
    $finish;
  end

endmodule
